// ===== rtl/core/ddodo_pkg.sv =====
`default_nettype none

package ddodo_pkg;

   localparam logic [23:0] WHEEL_RADIUS_RESET = 24'd655360;
   localparam logic [25:0] TRACK_WIDTH_RESET  = 26'd3276800;

   // register indexes of the control port
   localparam logic CSR_WHEEL_RADIUS = 1'b0;
   localparam logic CSR_TRACK_WIDTH  = 1'b1;

   // round(2^32 / (2 pi)): radians to binary angle
   localparam logic [30:0] TURN_PER_RAD   = 31'd683565276;
   // cordic gain compensation, q30
   localparam logic [32:0] CORDIC_GAIN    = 33'd652032874;
   // us to s
   localparam logic [30:0] MICRO_PER_SEC  = 31'd1000000;
   // binary angle to degrees, paired with a divide by 128
   localparam logic [30:0] DEG_PER_TURN   = 31'd703125;
   localparam logic [62:0] TURN_CLAMP     = 63'h0000_0800_0000_0000;

   localparam logic [6:0] MUL_STEPS    = 7'd31;
   localparam logic [6:0] DIV_STEPS    = 7'd64;
   localparam logic [6:0] CORDIC_STEPS = 7'd28;

   // arctangent table, binary angle units
   function automatic logic [29:0] atan_bam(input logic [4:0] i);
      logic [29:0] v;
      unique case (i)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         5'd24: v = 30'd41;
         5'd25: v = 30'd20;
         5'd26: v = 30'd10;
         5'd27: v = 30'd5;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   // magnitude plus sign to saturated 32 bit signed
   function automatic logic [31:0] sat32(input logic [63:0] mag, input logic neg);
      logic [63:0] n;
      logic [31:0] r;
      n = -mag;
      if (!neg) begin
         r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end else begin
         r = (mag > 64'h8000_0000) ? 32'h8000_0000 : n[31:0];
      end
      return r;
   endfunction

   // 48 bit signed saturating add
   function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
      logic [48:0] s;
      logic [47:0] r;
      s = {a[47], a} + {b[47], b};
      if (s[48] != s[47]) begin
         r = s[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
      end else begin
         r = s[47:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/differential_drive_odometry_top.sv =====
`default_nettype none

// wheel odometry for a two-wheel robot: each request carries the two wheel rotations
// and the elapsed time (integrate) or a new pose (reset); one response returns the
// whole odometry state after the request. arithmetic runs on one shift-add multiplier
// that takes one multiplier bit per cycle, one restoring divider that takes one
// quotient bit per cycle and one cordic stage used 28 times. a finished response
// waits in its own register, so the next request is taken while it is still pending.
// control registers are to be written by the user only while idle; the block does
// not enforce this.
module differential_drive_odometry_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_command,
   input  wire logic signed [23:0] req_left_wheel_angle,
   input  wire logic signed [23:0] req_right_wheel_angle,
   input  wire logic        [23:0] req_elapsed_time,
   input  wire logic signed [47:0] req_set_x,
   input  wire logic signed [47:0] req_set_y,
   input  wire logic signed [31:0] req_set_heading,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [47:0]      rsp_out_x,
   output logic signed [47:0]      rsp_out_y,
   output logic signed [31:0]      rsp_out_heading,
   output logic signed [47:0]      rsp_out_left_travel,
   output logic signed [47:0]      rsp_out_right_travel,
   output logic        [47:0]      rsp_out_path_length,
   output logic signed [31:0]      rsp_out_velocity_x,
   output logic signed [31:0]      rsp_out_velocity_y,
   output logic signed [31:0]      rsp_out_turn_rate,
   input  wire logic               csr_write_enable,
   input  wire logic               csr_index,
   input  wire logic        [25:0] csr_write_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL_L, S_MUL_R, S_MUL_Q, S_DIV_Q, S_CORDIC, S_MUL_X, S_MUL_Y,
      S_MUL_VX, S_DIV_VX, S_MUL_VY, S_DIV_VY, S_MUL_TR, S_DIV_TR, S_COMMIT
   } state_type;

   state_type state_ff;
   logic       busy_ff;
   logic [6:0] cnt_ff;

   // configuration
   logic [23:0] radius_ff;
   logic [25:0] track_ff;

   // captured request
   logic        cmd_ff;
   logic [23:0] la_ff, ra_ff, t_ff;
   logic [47:0] sx_ff, sy_ff;
   logic [31:0] sh_ff;

   // odometry state
   logic [47:0] pos_x_ff, pos_y_ff, ltrav_ff, rtrav_ff, path_ff;
   logic [31:0] heading_ff, vel_x_ff, vel_y_ff, turn_ff;

   // intermediates
   logic [31:0] dl_ff, dr_ff;
   logic [62:0] q_mag_ff;
   logic        q_neg_ff;
   logic [32:0] cos_ff, sin_ff;
   logic [33:0] dx_ff, dy_ff;

   // serial multiplier
   logic [63:0] mul_acc_ff, mul_a_ff;
   logic [30:0] mul_b_ff;
   logic        mul_neg_ff;

   // serial divider
   logic [30:0] div_rem_ff, div_den_ff;
   logic [63:0] div_num_ff;
   logic        div_neg_ff;

   // cordic stage
   logic signed [32:0] cx_ff, cy_ff, cz_ff;
   logic               cneg_ff;

   // response register
   logic        rsp_valid_ff;
   logic [47:0] rsp_x_ff, rsp_y_ff, rsp_lt_ff, rsp_rt_ff, rsp_path_ff;
   logic [31:0] rsp_h_ff, rsp_vx_ff, rsp_vy_ff, rsp_tr_ff;

   // combinational helpers
   logic [32:0] c_sum, diff, diff_mag;
   logic [31:0] c_val, c_mag;
   logic [23:0] la_mag, ra_mag;
   logic [32:0] cos_mag, sin_mag;
   logic [33:0] dx_mag, dy_mag;
   logic [63:0] q_sig, mul_signed;
   logic [43:0] op_a;
   logic [30:0] op_b, den_sel;
   logic        op_neg;
   logic [31:0] trial;
   logic [30:0] trial_sub;
   logic        trial_ge;
   logic [31:0] mid_ang, wrap_chk;
   logic [4:0]  ci;
   logic signed [32:0] cxs, cys, cat;
   logic [48:0] path_sum;
   logic [47:0] path_new;
   logic        commit_go;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign rsp_out_x            = rsp_x_ff;
   assign rsp_out_y            = rsp_y_ff;
   assign rsp_out_heading      = rsp_h_ff;
   assign rsp_out_left_travel  = rsp_lt_ff;
   assign rsp_out_right_travel = rsp_rt_ff;
   assign rsp_out_path_length  = rsp_path_ff;
   assign rsp_out_velocity_x   = rsp_vx_ff;
   assign rsp_out_velocity_y   = rsp_vy_ff;
   assign rsp_out_turn_rate    = rsp_tr_ff;

   // commit once the response register is free
   assign commit_go = (state_ff == S_COMMIT) && (!rsp_valid_ff || rsp_ready);

   // centre distance and wheel difference
   assign c_sum    = {dl_ff[31], dl_ff} + {dr_ff[31], dr_ff};
   assign c_val    = c_sum[32:1];
   assign c_mag    = c_val[31] ? -c_val : c_val;
   assign diff     = {dr_ff[31], dr_ff} - {dl_ff[31], dl_ff};
   assign diff_mag = diff[32] ? -diff : diff;
   assign la_mag   = la_ff[23] ? -la_ff : la_ff;
   assign ra_mag   = ra_ff[23] ? -ra_ff : ra_ff;
   assign cos_mag  = cos_ff[32] ? -cos_ff : cos_ff;
   assign sin_mag  = sin_ff[32] ? -sin_ff : sin_ff;
   assign dx_mag   = dx_ff[33] ? -dx_ff : dx_ff;
   assign dy_mag   = dy_ff[33] ? -dy_ff : dy_ff;
   assign q_sig    = q_neg_ff ? -{1'b0, q_mag_ff} : {1'b0, q_mag_ff};
   assign mul_signed = mul_neg_ff ? -mul_acc_ff : mul_acc_ff;

   // midpoint heading and quadrant fold
   assign mid_ang  = heading_ff + q_sig[32:1];
   assign wrap_chk = mid_ang + 32'h4000_0000;

   // multiplier operands per step of the sequence
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_neg = 1'b0;
      unique case (state_ff)
         S_MUL_L: begin
            op_a = {20'd0, la_mag}; op_b = {7'd0, radius_ff}; op_neg = la_ff[23];
         end
         S_MUL_R: begin
            op_a = {20'd0, ra_mag}; op_b = {7'd0, radius_ff}; op_neg = ra_ff[23];
         end
         S_MUL_Q: begin
            op_a = {11'd0, diff_mag}; op_b = ddodo_pkg::TURN_PER_RAD; op_neg = diff[32];
         end
         S_MUL_X: begin
            op_a = {12'd0, c_mag}; op_b = cos_mag[30:0]; op_neg = c_val[31] ^ cos_ff[32];
         end
         S_MUL_Y: begin
            op_a = {12'd0, c_mag}; op_b = sin_mag[30:0]; op_neg = c_val[31] ^ sin_ff[32];
         end
         S_MUL_VX: begin
            op_a = {10'd0, dx_mag}; op_b = ddodo_pkg::MICRO_PER_SEC; op_neg = dx_ff[33];
         end
         S_MUL_VY: begin
            op_a = {10'd0, dy_mag}; op_b = ddodo_pkg::MICRO_PER_SEC; op_neg = dy_ff[33];
         end
         S_MUL_TR: begin
            // turn clamp never changes the saturated rate
            op_a   = (q_mag_ff > ddodo_pkg::TURN_CLAMP) ? ddodo_pkg::TURN_CLAMP[43:0]
                                                         : q_mag_ff[43:0];
            op_b   = ddodo_pkg::DEG_PER_TURN;
            op_neg = q_neg_ff;
         end
         default: begin
            op_a   = '0;
            op_b   = '0;
            op_neg = 1'b0;
         end
      endcase
   end

   // divisor: track width (zero taken as one), the elapsed time for the velocities,
   // or 128 times the elapsed time for the turn rate
   assign den_sel = (state_ff == S_DIV_Q) ?
                    ((track_ff == 26'd0) ? 31'd1 : {5'd0, track_ff}) :
                    ((state_ff == S_DIV_TR) ? {t_ff, 7'd0} : {7'd0, t_ff});

   // restoring divide step
   assign trial     = {div_rem_ff, div_num_ff[63]};
   assign trial_ge  = (trial >= {1'b0, div_den_ff});
   assign trial_sub = 31'(trial - {1'b0, div_den_ff});

   // cordic micro-rotation
   assign ci  = cnt_ff[4:0];
   assign cxs = cx_ff >>> ci;
   assign cys = cy_ff >>> ci;
   assign cat = $signed({3'd0, ddodo_pkg::atan_bam(ci)});

   assign path_sum = {1'b0, path_ff} + {17'd0, c_mag};
   assign path_new = path_sum[48] ? 48'hFFFF_FFFF_FFFF : path_sum[47:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= ddodo_pkg::WHEEL_RADIUS_RESET;
         track_ff     <= ddodo_pkg::TRACK_WIDTH_RESET;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         heading_ff   <= '0;
         ltrav_ff     <= '0;
         rtrav_ff     <= '0;
         path_ff      <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         turn_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               ddodo_pkg::CSR_WHEEL_RADIUS: radius_ff <= csr_write_data[23:0];
               ddodo_pkg::CSR_TRACK_WIDTH:  track_ff  <= csr_write_data;
               default: ;
            endcase
         end

         if (commit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_command;
                  la_ff    <= req_left_wheel_angle;
                  ra_ff    <= req_right_wheel_angle;
                  t_ff     <= req_elapsed_time;
                  sx_ff    <= req_set_x;
                  sy_ff    <= req_set_y;
                  sh_ff    <= req_set_heading;
                  busy_ff  <= 1'b0;
                  state_ff <= req_command ? S_COMMIT : S_MUL_L;
               end
            end

            S_MUL_L, S_MUL_R, S_MUL_Q, S_MUL_X, S_MUL_Y, S_MUL_VX, S_MUL_VY,
            S_MUL_TR: begin
               if (!busy_ff) begin
                  mul_acc_ff <= '0;
                  mul_a_ff   <= {20'd0, op_a};
                  mul_b_ff   <= op_b;
                  mul_neg_ff <= op_neg;
                  cnt_ff     <= '0;
                  busy_ff    <= 1'b1;
               end else if (cnt_ff != ddodo_pkg::MUL_STEPS) begin
                  if (mul_b_ff[0]) begin
                     mul_acc_ff <= mul_acc_ff + mul_a_ff;
                  end
                  mul_a_ff <= {mul_a_ff[62:0], 1'b0};
                  mul_b_ff <= {1'b0, mul_b_ff[30:1]};
                  cnt_ff   <= cnt_ff + 7'd1;
               end else begin
                  busy_ff <= 1'b0;
                  unique case (state_ff)
                     S_MUL_L: begin
                        dl_ff    <= mul_signed[47:16];
                        state_ff <= S_MUL_R;
                     end
                     S_MUL_R: begin
                        dr_ff    <= mul_signed[47:16];
                        state_ff <= S_MUL_Q;
                     end
                     S_MUL_Q:  state_ff <= S_DIV_Q;
                     S_MUL_X: begin
                        dx_ff    <= mul_signed[63:30];
                        state_ff <= S_MUL_Y;
                     end
                     S_MUL_Y: begin
                        dy_ff    <= mul_signed[63:30];
                        state_ff <= (t_ff != 24'd0) ? S_MUL_VX : S_COMMIT;
                     end
                     S_MUL_VX: state_ff <= S_DIV_VX;
                     S_MUL_VY: state_ff <= S_DIV_VY;
                     default:  state_ff <= S_DIV_TR;
                  endcase
               end
            end

            S_DIV_Q, S_DIV_VX, S_DIV_VY, S_DIV_TR: begin
               if (!busy_ff) begin
                  // numerator comes straight from the multiplier, as magnitude and sign
                  div_num_ff <= mul_acc_ff;
                  div_neg_ff <= mul_neg_ff;
                  div_den_ff <= den_sel;
                  div_rem_ff <= '0;
                  cnt_ff     <= '0;
                  busy_ff    <= 1'b1;
               end else if (cnt_ff != ddodo_pkg::DIV_STEPS) begin
                  div_rem_ff <= trial_ge ? trial_sub : trial[30:0];
                  div_num_ff <= {div_num_ff[62:0], trial_ge};
                  cnt_ff     <= cnt_ff + 7'd1;
               end else begin
                  busy_ff <= 1'b0;
                  unique case (state_ff)
                     S_DIV_Q: begin
                        q_mag_ff <= div_num_ff[62:0];
                        q_neg_ff <= div_neg_ff;
                        state_ff <= S_CORDIC;
                     end
                     S_DIV_VX: begin
                        vel_x_ff <= ddodo_pkg::sat32(div_num_ff, div_neg_ff);
                        state_ff <= S_MUL_VY;
                     end
                     S_DIV_VY: begin
                        vel_y_ff <= ddodo_pkg::sat32(div_num_ff, div_neg_ff);
                        state_ff <= S_MUL_TR;
                     end
                     default: begin
                        turn_ff  <= ddodo_pkg::sat32(div_num_ff, div_neg_ff);
                        state_ff <= S_COMMIT;
                     end
                  endcase
               end
            end

            S_CORDIC: begin
               if (!busy_ff) begin
                  // fold the back half plane onto the front, negate results later
                  cx_ff   <= $signed(ddodo_pkg::CORDIC_GAIN);
                  cy_ff   <= '0;
                  cneg_ff <= wrap_chk[31];
                  cz_ff   <= wrap_chk[31] ?
                             $signed({~mid_ang[31], ~mid_ang[31], mid_ang[30:0]}) :
                             $signed({mid_ang[31], mid_ang});
                  cnt_ff  <= '0;
                  busy_ff <= 1'b1;
               end else if (cnt_ff != ddodo_pkg::CORDIC_STEPS) begin
                  if (!cz_ff[32]) begin
                     cx_ff <= cx_ff - cys;
                     cy_ff <= cy_ff + cxs;
                     cz_ff <= cz_ff - cat;
                  end else begin
                     cx_ff <= cx_ff + cys;
                     cy_ff <= cy_ff - cxs;
                     cz_ff <= cz_ff + cat;
                  end
                  cnt_ff <= cnt_ff + 7'd1;
               end else begin
                  cos_ff   <= cneg_ff ? -cx_ff : cx_ff;
                  sin_ff   <= cneg_ff ? -cy_ff : cy_ff;
                  busy_ff  <= 1'b0;
                  state_ff <= S_MUL_X;
               end
            end

            S_COMMIT: begin
               // wait for the response register to be free
               if (commit_go) begin
                  state_ff     <= S_IDLE;
                  if (cmd_ff) begin
                     pos_x_ff    <= sx_ff;
                     pos_y_ff    <= sy_ff;
                     heading_ff  <= sh_ff;
                     ltrav_ff    <= '0;
                     rtrav_ff    <= '0;
                     path_ff     <= '0;
                     vel_x_ff    <= '0;
                     vel_y_ff    <= '0;
                     turn_ff     <= '0;
                     rsp_x_ff    <= sx_ff;
                     rsp_y_ff    <= sy_ff;
                     rsp_h_ff    <= sh_ff;
                     rsp_lt_ff   <= '0;
                     rsp_rt_ff   <= '0;
                     rsp_path_ff <= '0;
                     rsp_vx_ff   <= '0;
                     rsp_vy_ff   <= '0;
                     rsp_tr_ff   <= '0;
                  end else begin
                     pos_x_ff    <= ddodo_pkg::sat_add48(pos_x_ff, {{14{dx_ff[33]}}, dx_ff});
                     pos_y_ff    <= ddodo_pkg::sat_add48(pos_y_ff, {{14{dy_ff[33]}}, dy_ff});
                     heading_ff  <= heading_ff + q_sig[31:0];
                     ltrav_ff    <= ddodo_pkg::sat_add48(ltrav_ff, {{16{dl_ff[31]}}, dl_ff});
                     rtrav_ff    <= ddodo_pkg::sat_add48(rtrav_ff, {{16{dr_ff[31]}}, dr_ff});
                     path_ff     <= path_new;
                     rsp_x_ff    <= ddodo_pkg::sat_add48(pos_x_ff, {{14{dx_ff[33]}}, dx_ff});
                     rsp_y_ff    <= ddodo_pkg::sat_add48(pos_y_ff, {{14{dy_ff[33]}}, dy_ff});
                     rsp_h_ff    <= heading_ff + q_sig[31:0];
                     rsp_lt_ff   <= ddodo_pkg::sat_add48(ltrav_ff, {{16{dl_ff[31]}}, dl_ff});
                     rsp_rt_ff   <= ddodo_pkg::sat_add48(rtrav_ff, {{16{dr_ff[31]}}, dr_ff});
                     rsp_path_ff <= path_new;
                     // rates were already refreshed in place when time was nonzero
                     rsp_vx_ff   <= vel_x_ff;
                     rsp_vy_ff   <= vel_y_ff;
                     rsp_tr_ff   <= turn_ff;
                  end
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== dv/tb_differential_drive_odometry_top.sv =====
`default_nettype none

module tb_differential_drive_odometry_top;

   timeunit 1ns;
   timeprecision 1ps;

   // watchdog limit on the cycle count of the whole run, far above the slowest request
   localparam int unsigned CYCLE_LIMIT  = 4000000;
   localparam int unsigned DRAIN_CYCLES = 700;
   localparam int          PHASE_ITEMS  = 206;

   localparam longint MAX48  = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint MIN48  = -MAX48 - 1;
   localparam longint UMAX48 = 64'sh0000_FFFF_FFFF_FFFF;
   localparam longint MAX32  = 64'sh0000_0000_7FFF_FFFF;
   localparam longint MIN32  = -MAX32 - 1;

   localparam logic CMD_INTEGRATE = 1'b0;
   localparam logic CMD_SET_POSE  = 1'b1;

   // full odometry state as returned by one response
   typedef struct {
      logic [47:0] x;
      logic [47:0] y;
      logic [31:0] hd;
      logic [47:0] lt;
      logic [47:0] rt;
      logic [47:0] pl;
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] tr;
   } odom_state_type;

   // directed stimulus row; pose_known marks rows whose response is typed in
   typedef struct {
      logic               cmd;
      logic signed [23:0] la;
      logic signed [23:0] ra;
      logic        [23:0] t;
      logic signed [47:0] sx;
      logic signed [47:0] sy;
      logic signed [31:0] sh;
      bit                 pose_known;
   } odom_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_command = CMD_INTEGRATE;
   logic signed [23:0] req_left_wheel_angle = '0;
   logic signed [23:0] req_right_wheel_angle = '0;
   logic        [23:0] req_elapsed_time = '0;
   logic signed [47:0] req_set_x = '0;
   logic signed [47:0] req_set_y = '0;
   logic signed [31:0] req_set_heading = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [47:0] rsp_out_x;
   logic signed [47:0] rsp_out_y;
   logic signed [31:0] rsp_out_heading;
   logic signed [47:0] rsp_out_left_travel;
   logic signed [47:0] rsp_out_right_travel;
   logic        [47:0] rsp_out_path_length;
   logic signed [31:0] rsp_out_velocity_x;
   logic signed [31:0] rsp_out_velocity_y;
   logic signed [31:0] rsp_out_turn_rate;
   logic               csr_write_enable = 1'b0;
   logic               csr_index = ddodo_pkg::CSR_WHEEL_RADIUS;
   logic        [25:0] csr_write_data = '0;

   differential_drive_odometry_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_left_wheel_angle (req_left_wheel_angle),
      .req_right_wheel_angle(req_right_wheel_angle),
      .req_elapsed_time     (req_elapsed_time),
      .req_set_x            (req_set_x),
      .req_set_y            (req_set_y),
      .req_set_heading      (req_set_heading),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_x            (rsp_out_x),
      .rsp_out_y            (rsp_out_y),
      .rsp_out_heading      (rsp_out_heading),
      .rsp_out_left_travel  (rsp_out_left_travel),
      .rsp_out_right_travel (rsp_out_right_travel),
      .rsp_out_path_length  (rsp_out_path_length),
      .rsp_out_velocity_x   (rsp_out_velocity_x),
      .rsp_out_velocity_y   (rsp_out_velocity_y),
      .rsp_out_turn_rate    (rsp_out_turn_rate),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // predictor: shadow copy of registers and odometry state
   // ---------------------------------------------------------------
   logic [23:0] model_radius = ddodo_pkg::WHEEL_RADIUS_RESET;
   logic [25:0] model_track  = ddodo_pkg::TRACK_WIDTH_RESET;
   longint      pos_x, pos_y, travel_l, travel_r, path_len, vel_x, vel_y, yaw_rate;
   logic [31:0] yaw;

   odom_state_type pending_states[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   // arctangent steps in binary angle units
   longint atan_steps [28] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
      5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
      10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // cos and sin in q30 of a binary angle
   task automatic rotate_unit(input logic [31:0] ang, output longint cs, output longint sn);
      logic   [31:0] a;
      logic   [31:0] probe;
      bit            flip;
      longint        xv, yv, zv, xs, ys;
      a     = ang;
      probe = a + 32'h4000_0000;
      flip  = probe[31];
      if (flip) a = a + 32'h8000_0000;
      zv = longint'($signed(a));
      xv = 652032874;
      yv = 0;
      for (int i = 0; i < 28; i++) begin
         xs = xv >>> i;
         ys = yv >>> i;
         if (zv >= 0) begin
            xv -= ys; yv += xs; zv -= atan_steps[i];
         end else begin
            xv += ys; yv -= xs; zv += atan_steps[i];
         end
      end
      cs = flip ? -xv : xv;
      sn = flip ? -yv : yv;
   endtask

   task automatic clear_odometry();
      pos_x = 0; pos_y = 0; yaw = '0;
      travel_l = 0; travel_r = 0; path_len = 0;
      vel_x = 0; vel_y = 0; yaw_rate = 0;
   endtask

   function automatic odom_state_type snapshot();
      odom_state_type s;
      s.x  = pos_x[47:0];    s.y  = pos_y[47:0];    s.hd = yaw;
      s.lt = travel_l[47:0]; s.rt = travel_r[47:0]; s.pl = path_len[47:0];
      s.vx = vel_x[31:0];    s.vy = vel_y[31:0];    s.tr = yaw_rate[31:0];
      return s;
   endfunction

   // applies one request to the shadow state and returns the resulting state
   task automatic advance_odometry(input odom_row_type r, output odom_state_type s);
      longint      w, dl, dr, ctr, q, qh, cs, sn, dx, dy, tt, qc;
      logic [31:0] mid;
      if (r.cmd == CMD_SET_POSE) begin
         clear_odometry();
         pos_x = longint'(r.sx);
         pos_y = longint'(r.sy);
         yaw   = r.sh;
      end else begin
         w   = (model_track == 0) ? 1 : longint'(model_track);
         dl  = (longint'(r.la) * longint'(model_radius)) >>> 16;
         dr  = (longint'(r.ra) * longint'(model_radius)) >>> 16;
         ctr = (dl + dr) >>> 1;
         q   = ((dr - dl) * 683565276) / w;
         qh  = q >>> 1;
         mid = yaw + qh[31:0];
         rotate_unit(mid, cs, sn);
         dx  = (ctr * cs) >>> 30;
         dy  = (ctr * sn) >>> 30;
         pos_x    = clip(pos_x + dx, MIN48, MAX48);
         pos_y    = clip(pos_y + dy, MIN48, MAX48);
         yaw      = yaw + q[31:0];
         travel_l = clip(travel_l + dl, MIN48, MAX48);
         travel_r = clip(travel_r + dr, MIN48, MAX48);
         path_len = clip(path_len + ((ctr < 0) ? -ctr : ctr), 0, UMAX48);
         // zero elapsed time keeps the last velocities
         if (r.t != 0) begin
            tt       = longint'(r.t);
            qc       = clip(q, -(64'sd1 <<< 43), 64'sd1 <<< 43);
            vel_x    = clip(dx * 1000000 / tt, MIN32, MAX32);
            vel_y    = clip(dy * 1000000 / tt, MIN32, MAX32);
            yaw_rate = clip(qc * 703125 / (128 * tt), MIN32, MAX32);
         end
      end
      s = snapshot();
   endtask

   // ---------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------
   task automatic report_mismatch(input string field, input logic [47:0] got,
                                  input logic [47:0] want);
      mismatch_count++;
      $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want, cycle_count);
   endtask

   // response monitor, sampled at the rising edge
   always @(posedge clock) begin
      odom_state_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_states.size() == 0) begin
            mismatch_count++;
            $display("unexpected response at cycle %0d", cycle_count);
         end else begin
            e = pending_states.pop_front();
            if (rsp_out_x !== e.x) report_mismatch("x", rsp_out_x, e.x);
            if (rsp_out_y !== e.y) report_mismatch("y", rsp_out_y, e.y);
            if (rsp_out_heading !== e.hd) report_mismatch("heading", rsp_out_heading, e.hd);
            if (rsp_out_left_travel !== e.lt)
               report_mismatch("left_travel", rsp_out_left_travel, e.lt);
            if (rsp_out_right_travel !== e.rt)
               report_mismatch("right_travel", rsp_out_right_travel, e.rt);
            if (rsp_out_path_length !== e.pl)
               report_mismatch("path_length", rsp_out_path_length, e.pl);
            if (rsp_out_velocity_x !== e.vx)
               report_mismatch("velocity_x", rsp_out_velocity_x, e.vx);
            if (rsp_out_velocity_y !== e.vy)
               report_mismatch("velocity_y", rsp_out_velocity_y, e.vy);
            if (rsp_out_turn_rate !== e.tr)
               report_mismatch("turn_rate", rsp_out_turn_rate, e.tr);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL differential_drive_odometry_top");
         $finish;
      end
   end

   // response side back-pressure, changed at the falling edge
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else       rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   // registers are only written while the block is idle
   task automatic write_csr(input logic idx, input logic [25:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      if (idx == ddodo_pkg::CSR_WHEEL_RADIUS) model_radius = data[23:0];
      else                                    model_track  = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // wait for every response, then let the block settle
   task automatic wait_drained();
      while (pending_states.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // drives one request at the falling edge, holds it until accepted
   task automatic send_request(input odom_row_type r);
      odom_state_type s;
      while ($urandom_range(0, 99) < send_idle_pct) @(negedge clock);
      req_valid             = 1'b1;
      req_command           = r.cmd;
      req_left_wheel_angle  = r.la;
      req_right_wheel_angle = r.ra;
      req_elapsed_time      = r.t;
      req_set_x             = r.sx;
      req_set_y             = r.sy;
      req_set_heading       = r.sh;
      do @(posedge clock); while (!req_ready);
      advance_odometry(r, s);
      // a pose load is easy to read off: the given pose with everything else cleared
      if (r.pose_known) begin
         s = '{x: r.sx, y: r.sy, hd: r.sh, lt: '0, rt: '0, pl: '0, vx: '0, vy: '0, tr: '0};
      end
      pending_states.push_back(s);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // random request: mostly plausible motion, sometimes a pose load near the extremes
   function automatic odom_row_type random_request();
      odom_row_type r;
      int           pick;
      r.pose_known = 1'b0;
      r.sx = 48'({$urandom, $urandom});
      r.sy = 48'({$urandom, $urandom});
      r.sh = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
         r.cmd = CMD_SET_POSE;
         // park the pose near the saturation limits sometimes
         if ($urandom_range(0, 1)) r.sx = r.sx[47] ? 48'(MIN48 + $urandom_range(0, 255))
                                                   : 48'(MAX48 - $urandom_range(0, 255));
         if ($urandom_range(0, 1)) r.sy = r.sy[47] ? 48'(MIN48 + $urandom_range(0, 255))
                                                   : 48'(MAX48 - $urandom_range(0, 255));
      end else begin
         r.cmd = CMD_INTEGRATE;
      end
      r.la = 24'($urandom);
      r.la = r.la >>> $urandom_range(0, 23);
      // wheels usually turn alike, now and then independently
      if ($urandom_range(0, 2) != 0) r.ra = r.la + (24'($urandom) >>> $urandom_range(4, 23));
      else                           r.ra = 24'($urandom) >>> $urandom_range(0, 23);
      case ($urandom_range(0, 4))
         0:       r.t = '0;
         1:       r.t = 24'($urandom);
         2:       r.t = 24'($urandom_range(1, 16));
         default: r.t = 24'($urandom_range(1, 20000));
      endcase
      return r;
   endfunction

   // directed rows, run with the reset register values
   odom_row_type directed_rows[] = '{
      // nothing moves, nothing changes
      '{CMD_INTEGRATE, 24'sd0, 24'sd0, 24'd0, 48'sd0, 48'sd0, 32'sd0, 1'b0},
      // pose loads at the extremes, then back to zero
      '{CMD_SET_POSE, 24'sd5, -24'sd5, 24'd7, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
        32'h7FFF_FFFF, 1'b1},
      '{CMD_SET_POSE, 24'sd0, 24'sd0, 24'd0, 48'h8000_0000_0000, 48'h8000_0000_0000,
        32'h8000_0000, 1'b1},
      '{CMD_SET_POSE, 24'sd0, 24'sd0, 24'd0, 48'sd0, 48'sd0, 32'sd0, 1'b1},
      // full wheel angles, shortest and longest time
      '{CMD_INTEGRATE, 24'h7F_FFFF, 24'h7F_FFFF, 24'd1, 48'sd99, 48'sd99, 32'sd99, 1'b0},
      '{CMD_INTEGRATE, 24'h80_0000, 24'h80_0000, 24'd1, 48'sd0, 48'sd0, 32'sd0, 1'b0},
      '{CMD_INTEGRATE, 24'h7F_FFFF, 24'h80_0000, 24'hFF_FFFF, 48'sd0, 48'sd0, 32'sd0, 1'b0},
      // zero time keeps the velocities
      '{CMD_INTEGRATE, 24'h80_0000, 24'h7F_FFFF, 24'd0, 48'sd0, 48'sd0, 32'sd0, 1'b0},
      '{CMD_INTEGRATE, -24'sd1, -24'sd1, 24'd1, 48'sd0, 48'sd0, 32'sd0, 1'b0},
      '{CMD_INTEGRATE, 24'sd1, -24'sd1, 24'd3, 48'sd0, 48'sd0, 32'sd0, 1'b0},
      // drive into the positive position limit
      '{CMD_SET_POSE, 24'sd0, 24'sd0, 24'd0, 48'h7FFF_FFFF_FF00, 48'h7FFF_FFFF_FF00,
        32'h2000_0000, 1'b1},
      '{CMD_INTEGRATE, 24'h7F_FFFF, 24'h7F_FFFF, 24'd1000, 48'sd0, 48'sd0, 32'sd0, 1'b0},
      // and into the negative one, heading near the half-turn wrap
      '{CMD_SET_POSE, 24'sd0, 24'sd0, 24'd0, 48'h8000_0000_0100, 48'h8000_0000_0100,
        32'h7FFF_0000, 1'b1},
      '{CMD_INTEGRATE, 24'h7F_FFFF, 24'h7F_FFFF, 24'd1, 48'sd0, 48'sd0, 32'sd0, 1'b0},
      '{CMD_INTEGRATE, 24'h10_0000, 24'h7F_FFFF, 24'd500, 48'sd0, 48'sd0, 32'sd0, 1'b0},
      // heading at and just inside the quarter-turn boundaries
      '{CMD_SET_POSE, 24'sd0, 24'sd0, 24'd0, 48'sd0, 48'sd0, 32'h3FFF_FFFF, 1'b1},
      '{CMD_INTEGRATE, 24'sd65536, 24'sd65536, 24'd10, 48'sd0, 48'sd0, 32'sd0, 1'b0},
      '{CMD_SET_POSE, 24'sd0, 24'sd0, 24'd0, 48'sd0, 48'sd0, 32'hC000_0000, 1'b1},
      '{CMD_INTEGRATE, 24'sd65536, 24'sd70000, 24'd10, 48'sd0, 48'sd0, 32'sd0, 1'b0}
   };

   // register settings per random phase, extremes included; zero track acts as one
   logic [23:0] phase_radius [6] = '{ddodo_pkg::WHEEL_RADIUS_RESET, 24'hFF_FFFF, 24'd1,
                                     24'hFF_FFFF, 24'd655360, 24'd3000000};
   logic [25:0] phase_track  [6] = '{ddodo_pkg::TRACK_WIDTH_RESET, 26'd1, 26'h3FF_FFFF,
                                     26'h3FF_FFFF, 26'd0, 26'd2000000};
   int          phase_send   [6] = '{0, 66, 0, 35, 0, 66};
   int          phase_recv   [6] = '{0, 0, 66, 35, 0, 35};

   initial begin
      clear_odometry();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, no idling
      foreach (directed_rows[i]) send_request(directed_rows[i]);

      for (int p = 0; p < 6; p++) begin
         wait_drained();
         write_csr(ddodo_pkg::CSR_WHEEL_RADIUS, {2'b00, phase_radius[p]});
         write_csr(ddodo_pkg::CSR_TRACK_WIDTH, phase_track[p]);
         send_idle_pct  = phase_send[p];
         recv_stall_pct = phase_recv[p];
         for (int n = 0; n < PHASE_ITEMS - 35; n++) begin
            // hold off once until everything has come back
            if (p == 1 && n == 50) while (pending_states.size() != 0) @(negedge clock);
            send_request(random_request());
         end
      end

      wait_drained();
      if (mismatch_count == 0) $display("PASS differential_drive_odometry_top");
      else                     $display("FAIL differential_drive_odometry_top");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/ddodo_pkg.sv
rtl/core/differential_drive_odometry_top.sv
dv/tb_differential_drive_odometry_top.sv
